// ----- rtl/core/mst_pkg.sv -----
// Shared types and constants for the multi-slot one-shot timer.
package mst_pkg;

  localparam int SLOTS_DEF = 10;

  localparam int FUNC_W   = 2;
  localparam int TIME_W   = 32;
  localparam int HANDLE_W = 4;
  localparam int KIND_W   = 3;

  localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CANCEL   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ELAPSE   = 2'd2;

  localparam logic [KIND_W-1:0] K_REGISTERED = 3'd0;
  localparam logic [KIND_W-1:0] K_FULL       = 3'd1;
  localparam logic [KIND_W-1:0] K_CANCELLED  = 3'd2;
  localparam logic [KIND_W-1:0] K_IGNORED    = 3'd3;
  localparam logic [KIND_W-1:0] K_EXPIRED    = 3'd4;
  localparam logic [KIND_W-1:0] K_NEXT       = 3'd5;

  localparam logic [TIME_W-1:0] NONE_WAIT = 32'hffff_ffff;

  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] remaining;
  } slot_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [TIME_W-1:0]   duration;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   elapsed;
  } req_t;

  typedef struct packed {
    logic              expired;
    logic              claimed;
    logic [TIME_W-1:0] best;
  } step_t;

endpackage

// ----- rtl/core/mst_ifs.sv -----
// Valid/ready channel interfaces for timer requests and results.
interface mst_req_if import mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [TIME_W-1:0]   duration;
  logic [HANDLE_W-1:0] handle;
  logic [TIME_W-1:0]   elapsed;

  modport source (output valid, func, duration, handle, elapsed, input ready);
  modport sink   (input valid, func, duration, handle, elapsed, output ready);
endinterface

interface mst_rsp_if import mst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] slot;
  logic [TIME_W-1:0]   next_wait;
  logic                last;

  modport source (output valid, kind, slot, next_wait, last, input ready);
  modport sink   (input valid, kind, slot, next_wait, last, output ready);
endinterface

// ----- rtl/core/mst_cell.sv -----
// One timer slot cell of the rotating slot ring.
module mst_cell import mst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t d,
  output slot_t q
);

  logic              active;
  logic [TIME_W-1:0] remaining;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (shift) begin
      active <= d.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      remaining <= d.remaining;
    end
  end

  assign q = '{active: active, remaining: remaining};

endmodule

// ----- rtl/core/mst_alu.sv -----
// Per-slot update unit: claim, cancel, or subtract-and-expire for the ring head.
module mst_alu import mst_pkg::*; (
  input  slot_t             cur,
  input  req_t              op,
  input  logic              hit,
  input  logic              found,
  input  logic [TIME_W-1:0] best,
  output slot_t             nxt,
  output step_t             st
);

  logic [TIME_W:0]   diff;
  logic              expire;

  assign diff   = {1'b0, cur.remaining} - {1'b0, op.elapsed};
  assign expire = diff[TIME_W] || (diff[TIME_W-1:0] == '0);

  always_comb begin
    nxt        = cur;
    st.expired = 1'b0;
    st.claimed = 1'b0;
    st.best    = best;
    case (op.func)
      FN_REGISTER: begin
        if (!cur.active && !found) begin
          nxt.active    = 1'b1;
          nxt.remaining = (op.duration == '0) ? TIME_W'(1) : op.duration;
          st.claimed    = 1'b1;
        end
      end
      FN_CANCEL: begin
        if (hit) begin
          nxt.active = 1'b0;
        end
      end
      FN_ELAPSE: begin
        if (cur.active) begin
          if (expire) begin
            nxt.active = 1'b0;
            st.expired = 1'b1;
          end else begin
            nxt.remaining = diff[TIME_W-1:0];
            if (diff[TIME_W-1:0] < best) begin
              st.best = diff[TIME_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/multi_slot_oneshot_timer.sv -----
// Multi-slot one-shot timer: a ring of slot cells walked by one update unit.
// Each register, cancel or elapse request walks the whole ring: the ring rotates one
// cell per cycle through the update unit unless a result stalls, then the final result.
// Unused selector requests are taken with no result and no ring walk.
// Result stalls hold the ring in place. Synchronous reset frees all slots at once.
module multi_slot_oneshot_timer import mst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  mst_req_if.sink    req,
  mst_rsp_if.source  rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state;
  logic [IW-1:0]       idx;
  logic                found;
  logic [HANDLE_W-1:0] found_slot;
  logic [TIME_W-1:0]   best;
  req_t                op;

  slot_t               cell_q [SLOTS];
  slot_t               cell_d [SLOTS];
  slot_t               alu_nxt;
  step_t               st;

  logic                can_emit;
  logic                step;
  logic                hit;
  logic                out_load;
  logic [KIND_W-1:0]   kind_next;
  logic [HANDLE_W-1:0] slot_next;
  logic [TIME_W-1:0]   wait_next;
  logic                last_next;

  assign can_emit = !rsp.valid || rsp.ready;
  assign step     = (state == ST_WALK) && can_emit;
  assign hit      = (op.handle == HANDLE_W'(idx));
  assign req.ready = (state == ST_IDLE);

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      assign cell_d[i] = alu_nxt;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    mst_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (step),
      .d     (cell_d[i]),
      .q     (cell_q[i])
    );
  end

  mst_alu u_alu (
    .cur   (cell_q[0]),
    .op    (op),
    .hit   (hit),
    .found (found),
    .best  (best),
    .nxt   (alu_nxt),
    .st    (st)
  );

  always_comb begin
    out_load  = 1'b0;
    kind_next = K_NEXT;
    slot_next = '0;
    wait_next = '0;
    last_next = 1'b0;
    if (state == ST_WALK) begin
      out_load  = step && st.expired;
      kind_next = K_EXPIRED;
      slot_next = HANDLE_W'(idx);
    end else if (state == ST_DONE) begin
      out_load  = can_emit;
      last_next = 1'b1;
      case (op.func)
        FN_REGISTER: begin
          kind_next = found ? K_REGISTERED : K_FULL;
          slot_next = found ? found_slot : '0;
        end
        FN_CANCEL: begin
          kind_next = (32'(op.handle) < SLOTS) ? K_CANCELLED : K_IGNORED;
          slot_next = op.handle;
        end
        default: begin
          kind_next = K_NEXT;
          wait_next = best;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            idx   <= '0;
            found <= 1'b0;
            if (req.func inside {FN_REGISTER, FN_CANCEL, FN_ELAPSE}) begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (step) begin
            if (st.claimed) begin
              found <= 1'b1;
            end
            if (idx == IW'(SLOTS - 1)) begin
              state <= ST_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (can_emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      op   <= '{func: req.func, duration: req.duration, handle: req.handle,
                elapsed: req.elapsed};
      best <= NONE_WAIT;
    end else if (step) begin
      best <= st.best;
      if (st.claimed) begin
        found_slot <= HANDLE_W'(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.kind      <= kind_next;
      rsp.slot      <= slot_next;
      rsp.next_wait <= wait_next;
      rsp.last      <= last_next;
    end
  end

  // final result only leaves from the done state
  a_last_in_done: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_next) |-> (state == ST_DONE))
    else $error("final result issued outside done state");

  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.func == FN_REGISTER || req.func == FN_CANCEL ||
     req.func == FN_ELAPSE)) |=> (state == ST_WALK && idx == '0))
    else $error("accepted request did not start a ring walk");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (32'(idx) < SLOTS))
    else $error("walk index beyond slot count");

  a_expire_only_elapse: assert property (@(posedge clk) disable iff (rst)
    (step && st.expired) |-> (op.func == FN_ELAPSE && cell_q[0].active))
    else $error("expiry outside an elapse request");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && rsp.valid && !rsp.ready) |=> $stable(idx))
    else $error("ring advanced while result stalled");

endmodule
